>>> rtl/mtlb_pkg.sv
`default_nettype none

package mtlb_pkg;

    localparam int TLB_DEPTH_DEFAULT = 16;

    localparam int WORD_W  = 32;
    localparam int DIV_W   = 17;
    localparam int OFF_W   = 16;
    localparam int IDX2_W  = 10;
    localparam int TBL_W   = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] CMD_TRANSLATE = 2'd0;
    localparam logic [1:0] CMD_FILL      = 2'd1;
    localparam logic [1:0] CMD_FLUSH     = 2'd2;

    localparam logic [1:0] ST_TRANSLATED = 2'd0;
    localparam logic [1:0] ST_MISS       = 2'd1;
    localparam logic [1:0] ST_FAULT      = 2'd2;
    localparam logic [1:0] ST_FLUSHED    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPL_MODE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_SIZE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_TABLE  = 3'd5;

    localparam logic MODE_FIFO          = 1'b0;
    localparam logic MODE_LEAST_REFD    = 1'b1;

    localparam logic [WORD_W-1:0] REFS_MAX = '1;

    typedef struct packed {
        logic [WORD_W-1:0] page;
        logic [WORD_W-1:0] frame;
        logic [WORD_W-1:0] refs;
    } entry_t;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] num;
        logic [DIV_W-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quo;
        logic [DIV_W-1:0]  rem;
    } div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/mtlb_div.sv
`default_nettype none

module mtlb_div (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire mtlb_pkg::div_req_t req,
    output mtlb_pkg::div_rsp_t    rsp
);

    logic [mtlb_pkg::WORD_W-1:0] quo_reg, quo_next;
    logic [mtlb_pkg::DIV_W-1:0]  rem_reg, rem_next;
    logic [mtlb_pkg::DIV_W-1:0]  den_reg, den_next;
    logic [5:0]                  cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [mtlb_pkg::DIV_W:0]    trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[mtlb_pkg::WORD_W-1]};
        if (req.start) begin
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = 6'(mtlb_pkg::WORD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = mtlb_pkg::DIV_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[mtlb_pkg::WORD_W-2:0], 1'b1};
            end else begin
                rem_next = trial[mtlb_pkg::DIV_W-1:0];
                quo_next = {quo_reg[mtlb_pkg::WORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

>>> rtl/mmu_tlb_translate.sv
// MMU front end with a TLB for two-level paging. One transfer on the s_ channel yields one
// transfer on the m_ channel, except command 3, which is taken and ignored. Items are handled
// one at a time. The page number and both table indexes of a translate come from a shared
// divider that retires one quotient bit per cycle, and the TLB entries sit in a
// single-port-read memory that the search walks one entry at a time, through a read state
// and a check state. A fill runs the retag sweep over every entry, the eviction check, the
// drop of the evicted head, the append, the index division and the handoff; in
// least-referenced mode the eviction first runs up to (n-1) bubble passes for n entries.
// The TLB memory needs no clearing after reset.
`default_nettype none

module mmu_tlb_translate #(
    parameter int TLB_DEPTH = mtlb_pkg::TLB_DEPTH_DEFAULT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [1:0]                        s_command,
    input  wire logic [mtlb_pkg::WORD_W-1:0]       s_logical_address,
    input  wire logic [mtlb_pkg::WORD_W-1:0]       s_walk_frame,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [1:0]                             m_status,
    output logic [mtlb_pkg::WORD_W-1:0]            m_page_number,
    output logic [mtlb_pkg::WORD_W-1:0]            m_frame,
    output logic [mtlb_pkg::OFF_W-1:0]             m_page_offset,
    output logic [mtlb_pkg::WORD_W-1:0]            m_first_level_index,
    output logic [mtlb_pkg::IDX2_W-1:0]            m_second_level_index,
    output logic [mtlb_pkg::TBL_W-1:0]             m_table_base,
    input  wire logic                              cfg_we,
    input  wire logic [mtlb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mtlb_pkg::WORD_W-1:0]       cfg_wdata
);

    localparam int IW   = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
    localparam int CW   = $clog2(TLB_DEPTH + 1);
    localparam int CAPW = 7;

    typedef enum logic [16:0] {
        S_IDLE       = 17'h00001,
        S_DIV_PAGE   = 17'h00002,
        S_DIV_IDX    = 17'h00004,
        S_SRCH_RD    = 17'h00008,
        S_SRCH_CHK   = 17'h00010,
        S_FILL_RD    = 17'h00020,
        S_FILL_CHK   = 17'h00040,
        S_EVICT      = 17'h00080,
        S_SORT_START = 17'h00100,
        S_SORT_LD    = 17'h00200,
        S_SORT_RD    = 17'h00400,
        S_SORT_CHK   = 17'h00800,
        S_SORT_END   = 17'h01000,
        S_SHIFT_RD   = 17'h02000,
        S_SHIFT_CHK  = 17'h04000,
        S_APPEND     = 17'h08000,
        S_FIN        = 17'h10000
    } state_t;

    state_t state_reg, state_next;

    logic [16:0]                    cfg_page_size_reg;
    logic [10:0]                    cfg_entries_reg;
    logic [4:0]                     cfg_capacity_reg;
    logic                           cfg_mode_reg;
    logic [mtlb_pkg::WORD_W-1:0]    cfg_process_size_reg;
    logic [mtlb_pkg::TBL_W-1:0]     cfg_first_table_reg;

    mtlb_pkg::entry_t               mem [TLB_DEPTH];
    mtlb_pkg::entry_t               rdata;
    mtlb_pkg::entry_t               wr_entry;
    logic [IW-1:0]                  rd_idx;
    logic [IW-1:0]                  wr_idx;
    logic                           mem_we;

    mtlb_pkg::div_req_t             div_req;
    mtlb_pkg::div_rsp_t             div_rsp;

    logic [1:0]                     cmd_reg, cmd_next;
    logic [mtlb_pkg::WORD_W-1:0]    wframe_reg, wframe_next;
    logic [mtlb_pkg::WORD_W-1:0]    page_reg, page_next;
    logic [mtlb_pkg::OFF_W-1:0]     off_reg, off_next;
    logic [mtlb_pkg::WORD_W-1:0]    idx1_reg, idx1_next;
    logic [mtlb_pkg::IDX2_W-1:0]    idx2_reg, idx2_next;
    logic [mtlb_pkg::WORD_W-1:0]    frame_reg, frame_next;
    logic [1:0]                     status_reg, status_next;
    logic [CW-1:0]                  j_reg, j_next;
    logic [CW-1:0]                  pass_reg, pass_next;
    mtlb_pkg::entry_t               carry_reg, carry_next;
    logic [CW-1:0]                  occ_reg, occ_next;
    logic [mtlb_pkg::WORD_W-1:0]    pend_page_reg, pend_page_next;
    logic [mtlb_pkg::OFF_W-1:0]     pend_off_reg, pend_off_next;

    logic                           m_valid_reg, m_valid_next;
    logic [1:0]                     m_status_reg, m_status_next;
    logic [mtlb_pkg::WORD_W-1:0]    m_page_reg, m_page_next;
    logic [mtlb_pkg::WORD_W-1:0]    m_frame_reg, m_frame_next;
    logic [mtlb_pkg::OFF_W-1:0]     m_off_reg, m_off_next;
    logic [mtlb_pkg::WORD_W-1:0]    m_idx1_reg, m_idx1_next;
    logic [mtlb_pkg::IDX2_W-1:0]    m_idx2_reg, m_idx2_next;
    logic [mtlb_pkg::TBL_W-1:0]     m_tbl_reg, m_tbl_next;

    logic [mtlb_pkg::DIV_W-1:0]     ps_eff;
    logic [mtlb_pkg::DIV_W-1:0]     ept_eff;
    logic [CAPW-1:0]                cap_eff;
    logic [CAPW-1:0]                occ_wide;
    logic [CW-1:0]                  j_plus;

    assign ps_eff   = (cfg_page_size_reg == '0) ? mtlb_pkg::DIV_W'(1) : cfg_page_size_reg;
    assign ept_eff  = (cfg_entries_reg == '0) ? mtlb_pkg::DIV_W'(1)
                                              : mtlb_pkg::DIV_W'(cfg_entries_reg);
    assign occ_wide = CAPW'(occ_reg);
    assign j_plus   = j_reg + CW'(1);

    always_comb begin
        if (cfg_capacity_reg == '0) begin
            cap_eff = CAPW'(1);
        end else if (CAPW'(cfg_capacity_reg) > CAPW'(TLB_DEPTH)) begin
            cap_eff = CAPW'(TLB_DEPTH);
        end else begin
            cap_eff = CAPW'(cfg_capacity_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_page_size_reg    <= 17'd64;
            cfg_entries_reg      <= 11'd4;
            cfg_capacity_reg     <= 5'd4;
            cfg_mode_reg         <= mtlb_pkg::MODE_FIFO;
            cfg_process_size_reg <= '0;
            cfg_first_table_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                mtlb_pkg::CFG_PAGE_SIZE:    cfg_page_size_reg    <= cfg_wdata[16:0];
                mtlb_pkg::CFG_ENTRIES:      cfg_entries_reg      <= cfg_wdata[10:0];
                mtlb_pkg::CFG_CAPACITY:     cfg_capacity_reg     <= cfg_wdata[4:0];
                mtlb_pkg::CFG_REPL_MODE:    cfg_mode_reg         <= cfg_wdata[0];
                mtlb_pkg::CFG_PROCESS_SIZE: cfg_process_size_reg <= cfg_wdata;
                mtlb_pkg::CFG_FIRST_TABLE:  cfg_first_table_reg  <= cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_idx] <= wr_entry;
        end
        rdata <= mem[rd_idx];
    end

    mtlb_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        wframe_next    = wframe_reg;
        page_next      = page_reg;
        off_next       = off_reg;
        idx1_next      = idx1_reg;
        idx2_next      = idx2_reg;
        frame_next     = frame_reg;
        status_next    = status_reg;
        j_next         = j_reg;
        pass_next      = pass_reg;
        carry_next     = carry_reg;
        occ_next       = occ_reg;
        pend_page_next = pend_page_reg;
        pend_off_next  = pend_off_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_status_next  = m_status_reg;
        m_page_next    = m_page_reg;
        m_frame_next   = m_frame_reg;
        m_off_next     = m_off_reg;
        m_idx1_next    = m_idx1_reg;
        m_idx2_next    = m_idx2_reg;
        m_tbl_next     = m_tbl_reg;
        mem_we         = 1'b0;
        wr_idx         = j_reg[IW-1:0];
        wr_entry       = rdata;
        rd_idx         = j_reg[IW-1:0];
        div_req.start  = 1'b0;
        div_req.num    = page_reg;
        div_req.den    = ept_eff;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next = s_command;
                    case (s_command)
                        mtlb_pkg::CMD_TRANSLATE: begin
                            if (s_logical_address >= cfg_process_size_reg) begin
                                status_next = mtlb_pkg::ST_FAULT;
                                page_next   = '0;
                                frame_next  = '0;
                                off_next    = '0;
                                idx1_next   = '0;
                                idx2_next   = '0;
                                state_next  = S_FIN;
                            end else begin
                                div_req.start = 1'b1;
                                div_req.num   = s_logical_address;
                                div_req.den   = ps_eff;
                                state_next    = S_DIV_PAGE;
                            end
                        end
                        mtlb_pkg::CMD_FILL: begin
                            wframe_next = s_walk_frame;
                            j_next      = '0;
                            state_next  = S_FILL_RD;
                        end
                        mtlb_pkg::CMD_FLUSH: begin
                            occ_next    = '0;
                            status_next = mtlb_pkg::ST_FLUSHED;
                            page_next   = '0;
                            frame_next  = '0;
                            off_next    = '0;
                            idx1_next   = '0;
                            idx2_next   = '0;
                            state_next  = S_FIN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV_PAGE: begin
                if (div_rsp.done) begin
                    page_next     = div_rsp.quo;
                    off_next      = div_rsp.rem[mtlb_pkg::OFF_W-1:0];
                    div_req.start = 1'b1;
                    div_req.num   = div_rsp.quo;
                    state_next    = S_DIV_IDX;
                end
            end
            S_DIV_IDX: begin
                if (div_rsp.done) begin
                    idx1_next = div_rsp.quo;
                    idx2_next = div_rsp.rem[mtlb_pkg::IDX2_W-1:0];
                    if (cmd_reg == mtlb_pkg::CMD_FILL) begin
                        status_next = mtlb_pkg::ST_TRANSLATED;
                        state_next  = S_FIN;
                    end else begin
                        j_next     = '0;
                        state_next = S_SRCH_RD;
                    end
                end
            end
            S_SRCH_RD: begin
                if (j_reg == occ_reg) begin
                    pend_page_next = page_reg;
                    pend_off_next  = off_reg;
                    status_next    = mtlb_pkg::ST_MISS;
                    frame_next     = '0;
                    state_next     = S_FIN;
                end else begin
                    state_next = S_SRCH_CHK;
                end
            end
            S_SRCH_CHK: begin
                if (rdata.page == page_reg) begin
                    mem_we = 1'b1;
                    if (rdata.refs != mtlb_pkg::REFS_MAX) begin
                        wr_entry.refs = rdata.refs + mtlb_pkg::WORD_W'(1);
                    end
                    frame_next  = rdata.frame;
                    status_next = mtlb_pkg::ST_TRANSLATED;
                    state_next  = S_FIN;
                end else begin
                    j_next     = j_plus;
                    state_next = S_SRCH_RD;
                end
            end
            S_FILL_RD: begin
                state_next = (j_reg == occ_reg) ? S_EVICT : S_FILL_CHK;
            end
            S_FILL_CHK: begin
                if (rdata.frame == wframe_reg && rdata.page != pend_page_reg) begin
                    mem_we        = 1'b1;
                    wr_entry.page = pend_page_reg;
                    wr_entry.refs = mtlb_pkg::WORD_W'(1);
                end
                j_next     = j_plus;
                state_next = S_FILL_RD;
            end
            S_EVICT: begin
                if (occ_wide >= cap_eff) begin
                    if (cfg_mode_reg == mtlb_pkg::MODE_LEAST_REFD && occ_reg > CW'(1)) begin
                        pass_next  = CW'(1);
                        j_next     = '0;
                        state_next = S_SORT_START;
                    end else begin
                        j_next     = CW'(1);
                        state_next = S_SHIFT_RD;
                    end
                end else begin
                    state_next = S_APPEND;
                end
            end
            S_SORT_START: begin
                state_next = S_SORT_LD;
            end
            S_SORT_LD: begin
                carry_next = rdata;
                j_next     = CW'(1);
                state_next = S_SORT_RD;
            end
            S_SORT_RD: begin
                state_next = S_SORT_CHK;
            end
            S_SORT_CHK: begin
                mem_we = 1'b1;
                wr_idx = IW'(j_reg - CW'(1));
                if (carry_reg.refs > rdata.refs) begin
                    wr_entry = rdata;
                end else begin
                    wr_entry   = carry_reg;
                    carry_next = rdata;
                end
                j_next     = j_plus;
                state_next = (j_plus == occ_reg) ? S_SORT_END : S_SORT_RD;
            end
            S_SORT_END: begin
                mem_we   = 1'b1;
                wr_idx   = IW'(occ_reg - CW'(1));
                wr_entry = carry_reg;
                if (pass_reg == occ_reg - CW'(1)) begin
                    j_next     = CW'(1);
                    state_next = S_SHIFT_RD;
                end else begin
                    pass_next  = pass_reg + CW'(1);
                    j_next     = '0;
                    state_next = S_SORT_START;
                end
            end
            S_SHIFT_RD: begin
                if (j_reg >= occ_reg) begin
                    occ_next   = occ_reg - CW'(1);
                    state_next = S_APPEND;
                end else begin
                    state_next = S_SHIFT_CHK;
                end
            end
            S_SHIFT_CHK: begin
                mem_we     = 1'b1;
                wr_idx     = IW'(j_reg - CW'(1));
                wr_entry   = rdata;
                j_next     = j_plus;
                state_next = S_SHIFT_RD;
            end
            S_APPEND: begin
                if (occ_wide < CAPW'(TLB_DEPTH)) begin
                    mem_we         = 1'b1;
                    wr_idx         = occ_reg[IW-1:0];
                    wr_entry.page  = pend_page_reg;
                    wr_entry.frame = wframe_reg;
                    wr_entry.refs  = mtlb_pkg::WORD_W'(1);
                    occ_next       = occ_reg + CW'(1);
                end
                page_next     = pend_page_reg;
                off_next      = pend_off_reg;
                frame_next    = wframe_reg;
                div_req.start = 1'b1;
                div_req.num   = pend_page_reg;
                state_next    = S_DIV_IDX;
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_page_next   = page_reg;
                    m_frame_next  = frame_reg;
                    m_off_next    = off_reg;
                    m_idx1_next   = idx1_reg;
                    m_idx2_next   = idx2_reg;
                    m_tbl_next    = cfg_first_table_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        wframe_reg   <= wframe_next;
        page_reg     <= page_next;
        off_reg      <= off_next;
        idx1_reg     <= idx1_next;
        idx2_reg     <= idx2_next;
        frame_reg    <= frame_next;
        status_reg   <= status_next;
        j_reg        <= j_next;
        pass_reg     <= pass_next;
        carry_reg    <= carry_next;
        m_status_reg <= m_status_next;
        m_page_reg   <= m_page_next;
        m_frame_reg  <= m_frame_next;
        m_off_reg    <= m_off_next;
        m_idx1_reg   <= m_idx1_next;
        m_idx2_reg   <= m_idx2_next;
        m_tbl_reg    <= m_tbl_next;
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            pend_page_reg <= '0;
            pend_off_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            pend_page_reg <= pend_page_next;
            pend_off_reg  <= pend_off_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    assign s_ready              = (state_reg == S_IDLE);
    assign m_valid              = m_valid_reg;
    assign m_status             = m_status_reg;
    assign m_page_number        = m_page_reg;
    assign m_frame              = m_frame_reg;
    assign m_page_offset        = m_off_reg;
    assign m_first_level_index  = m_idx1_reg;
    assign m_second_level_index = m_idx2_reg;
    assign m_table_base         = m_tbl_reg;

    // The TLB never holds more entries than the memory has rows.
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_wide <= CAPW'(TLB_DEPTH))
        else $error("TLB occupancy beyond depth");

    a_flush_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_command == mtlb_pkg::CMD_FLUSH) |=> (occ_reg == '0))
        else $error("flush did not empty the TLB");

    a_occ_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_valid && s_ready && s_command == mtlb_pkg::CMD_FLUSH) |=>
            (occ_reg == $past(occ_reg) || occ_reg == $past(occ_reg) + CW'(1) ||
             occ_reg == $past(occ_reg) - CW'(1)))
        else $error("TLB occupancy jumped");

    // A result leaves the sequencer only when the output register can take it.
    a_fin_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && m_valid_reg && !m_ready) |=> (state_reg == S_FIN))
        else $error("result dropped while output stalled");

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import mtlb_pkg::*;

    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic [1:0]        status;
        logic [WORD_W-1:0] page_number;
        logic [WORD_W-1:0] frame;
        logic [OFF_W-1:0]  page_offset;
        logic [WORD_W-1:0] first_idx;
        logic [IDX2_W-1:0] second_idx;
        logic [TBL_W-1:0]  table_base;
    } xlat_t;

    class tlb_scoreboard;
        logic [31:0] pg_size, ept, cap, mode, proc_size, flt;
        logic [31:0] e_page[DEPTH], e_frame[DEPTH], e_refs[DEPTH];
        int unsigned occ;
        logic [31:0] pend_page, pend_off;
        xlat_t pending_xlats[$];
        int errors;

        function new();
            pg_size = 64; ept = 4; cap = 4; mode = 0; proc_size = 0; flt = 0;
            occ = 0; pend_page = 0; pend_off = 0; errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
            case (idx)
                CFG_PAGE_SIZE:    pg_size = v & 32'h1FFFF;
                CFG_ENTRIES:      ept = v & 32'h7FF;
                CFG_CAPACITY:     cap = v & 32'h1F;
                CFG_REPL_MODE:    mode = v & 1;
                CFG_PROCESS_SIZE: proc_size = v;
                CFG_FIRST_TABLE:  flt = v & 32'hFFFF;
                default: ;
            endcase
        endfunction

        function xlat_t make(logic [1:0] st, logic [31:0] pg, logic [31:0] fr,
                             logic [31:0] off, bit idx);
            xlat_t r;
            logic [31:0] d;
            d = (ept == 0) ? 1 : ept;
            r.status = st;
            r.page_number = pg;
            r.frame = fr;
            r.page_offset = off[15:0];
            r.first_idx = idx ? pg / d : 0;
            r.second_idx = idx ? 10'(pg % d) : 0;
            r.table_base = flt[15:0];
            return r;
        endfunction

        function void remove_head();
            for (int i = 1; i < occ; i++) begin
                e_page[i-1] = e_page[i];
                e_frame[i-1] = e_frame[i];
                e_refs[i-1] = e_refs[i];
            end
            if (occ > 0) occ--;
        endfunction

        function void sort_by_count();
            logic [31:0] p, f, r;
            int j;
            for (int i = 1; i < occ; i++) begin
                p = e_page[i]; f = e_frame[i]; r = e_refs[i];
                j = i;
                while (j > 0 && e_refs[j-1] > r) begin
                    e_page[j] = e_page[j-1];
                    e_frame[j] = e_frame[j-1];
                    e_refs[j] = e_refs[j-1];
                    j--;
                end
                e_page[j] = p; e_frame[j] = f; e_refs[j] = r;
            end
        endfunction

        function void note_input(logic [1:0] cmd, logic [31:0] addr, logic [31:0] wf);
            logic [31:0] ps, pg, off;
            int unsigned lim;
            bit hit;
            if (cmd == CMD_TRANSLATE) begin
                ps = (pg_size == 0) ? 1 : pg_size;
                if (addr >= proc_size) begin
                    pending_xlats.push_back(make(ST_FAULT, 0, 0, 0, 0));
                end else begin
                    pg = addr / ps;
                    off = (addr % ps) & 32'hFFFF;
                    hit = 0;
                    for (int i = 0; i < occ && !hit; i++) begin
                        if (e_page[i] == pg) begin
                            hit = 1;
                            if (e_refs[i] != REFS_MAX) e_refs[i]++;
                            pending_xlats.push_back(make(ST_TRANSLATED, pg, e_frame[i],
                                                         off, 1));
                        end
                    end
                    if (!hit) begin
                        pend_page = pg;
                        pend_off = off;
                        pending_xlats.push_back(make(ST_MISS, pg, 0, off, 1));
                    end
                end
            end else if (cmd == CMD_FILL) begin
                for (int i = 0; i < occ; i++) begin
                    if (e_frame[i] == wf && e_page[i] != pend_page) begin
                        e_page[i] = pend_page;
                        e_refs[i] = 1;
                    end
                end
                lim = (cap < 1) ? 1 : (cap > DEPTH) ? DEPTH : cap;
                if (occ >= lim) begin
                    if (mode[0]) sort_by_count();
                    remove_head();
                end
                if (occ < DEPTH) begin
                    e_page[occ] = pend_page;
                    e_frame[occ] = wf;
                    e_refs[occ] = 1;
                    occ++;
                end
                pending_xlats.push_back(make(ST_TRANSLATED, pend_page, wf, pend_off, 1));
            end else if (cmd == CMD_FLUSH) begin
                occ = 0;
                pending_xlats.push_back(make(ST_FLUSHED, 0, 0, 0, 0));
            end
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch on %s: got %h, expected %h", what, got, want);
            errors++;
        endtask

        task check(xlat_t got);
            xlat_t w;
            if (pending_xlats.size() == 0) begin
                report("unexpected transfer", 32'(got.status), 0);
            end else begin
                w = pending_xlats.pop_front();
                if (got.status != w.status) report("status", 32'(got.status), 32'(w.status));
                if (got.page_number != w.page_number)
                    report("page_number", got.page_number, w.page_number);
                if (got.frame != w.frame) report("frame", got.frame, w.frame);
                if (got.page_offset != w.page_offset)
                    report("page_offset", 32'(got.page_offset), 32'(w.page_offset));
                if (got.first_idx != w.first_idx)
                    report("first_level_index", got.first_idx, w.first_idx);
                if (got.second_idx != w.second_idx)
                    report("second_level_index", 32'(got.second_idx), 32'(w.second_idx));
                if (got.table_base != w.table_base)
                    report("table_base", 32'(got.table_base), 32'(w.table_base));
            end
        endtask
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [1:0] s_command = 0;
    logic [31:0] s_logical_address = 0;
    logic [31:0] s_walk_frame = 0;
    logic m_valid;
    logic m_ready = 0;
    logic [1:0] m_status;
    logic [31:0] m_page_number, m_frame, m_first_level_index;
    logic [15:0] m_page_offset, m_table_base;
    logic [9:0] m_second_level_index;
    logic cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_index = 0;
    logic [31:0] cfg_wdata = 0;

    tlb_scoreboard sb = new();
    bit no_idle = 0;
    int unsigned cycles = 0;

    mmu_tlb_translate u_top (.*);

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge aclk) m_ready <= no_idle || ($urandom_range(99) >= 26);

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_input(s_command, s_logical_address, s_walk_frame);
        if (aresetn && m_valid && m_ready)
            sb.check({m_status, m_page_number, m_frame, m_page_offset,
                      m_first_level_index, m_second_level_index, m_table_base});
    end

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= v;
        sb.set_reg(idx, v);
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    task send(logic [1:0] cmd, logic [31:0] addr, logic [31:0] wf);
        while (!no_idle && $urandom_range(99) < 26) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_command <= cmd;
        s_logical_address <= addr;
        s_walk_frame <= wf;
        do @(posedge aclk); while (!s_ready);
    endtask

    task drain();
        s_valid <= 0;
        @(posedge aclk);
        while (sb.pending_xlats.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task random_item();
        int unsigned r, pg;
        logic [31:0] ps, fr;
        r = $urandom_range(99);
        ps = (sb.pg_size == 0) ? 1 : sb.pg_size;
        fr = ($urandom_range(9) == 0) ? ($urandom() % 32'hFFFFFFFF) : $urandom_range(24);
        if (r < 50) begin
            pg = $urandom_range(20);
            if ($urandom_range(9) == 0) send(CMD_TRANSLATE, $urandom(), fr);
            else send(CMD_TRANSLATE, pg * ps + ($urandom() % ps), fr);
        end else if (r < 88) begin
            send(CMD_FILL, $urandom(), fr);
        end else if (r < 95) begin
            send(CMD_FLUSH, $urandom(), $urandom());
        end else begin
            send(2'd3, $urandom(), $urandom());
        end
    endtask

    initial begin
        logic [31:0] ps_opts[6], ept_opts[6];
        ps_opts = '{1, 65536, 131071, 0, 4096, 16};
        ept_opts = '{1, 1024, 2047, 0, 4, 16};
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        send(CMD_TRANSLATE, 32'h0, 0);
        send(CMD_FILL, 0, 32'h5);
        send(CMD_FLUSH, 0, 0);
        send(2'd3, 32'hFFFFFFFF, 32'hFFFFFFFF);
        drain();
        write_reg(CFG_PAGE_SIZE, 0);
        write_reg(CFG_ENTRIES, 0);
        write_reg(CFG_CAPACITY, 0);
        write_reg(CFG_REPL_MODE, MODE_LEAST_REFD);
        write_reg(CFG_PROCESS_SIZE, 32'hFFFFFFFF);
        write_reg(CFG_FIRST_TABLE, 32'hFFFF);
        send(CMD_TRANSLATE, 32'h0, 0);
        send(CMD_TRANSLATE, 32'hFFFFFFFE, 0);
        send(CMD_TRANSLATE, 32'hFFFFFFFF, 0);
        send(CMD_FILL, 0, 32'hFFFFFFFE);
        send(CMD_FILL, 0, 0);
        send(CMD_TRANSLATE, 32'hFFFFFFFE, 0);
        drain();
        write_reg(CFG_PAGE_SIZE, 131071);
        write_reg(CFG_ENTRIES, 2047);
        write_reg(CFG_CAPACITY, 31);
        write_reg(CFG_REPL_MODE, MODE_FIFO);
        send(CMD_TRANSLATE, 32'hFFFFFFFE, 0);
        send(CMD_FILL, 0, 32'h7);
        send(CMD_TRANSLATE, 32'h00ABCDEF, 0);
        send(CMD_FILL, 0, 32'h7);
        send(CMD_TRANSLATE, 32'hFFFFFFFE, 0);
        send(CMD_TRANSLATE, 32'h00ABCDEF, 0);
        send(CMD_FLUSH, 0, 0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_PAGE_SIZE, ps_opts[$urandom_range(5)]);
            write_reg(CFG_ENTRIES, ept_opts[$urandom_range(5)]);
            write_reg(CFG_CAPACITY, (ph == 0) ? 16 : (ph == 1) ? 1 : $urandom_range(31));
            write_reg(CFG_REPL_MODE, ph % 2);
            write_reg(CFG_PROCESS_SIZE, (ph == 2) ? 32'd500 :
                      ($urandom_range(3) == 0) ? $urandom() : 32'hFFFFFFFF);
            write_reg(CFG_FIRST_TABLE, $urandom_range(16'hFFFF));
            no_idle = (ph == 3);
            for (int k = 0; k < 230; k++) begin
                random_item();
                if (ph == 4 && k == 100) drain();
            end
            drain();
        end
        no_idle = 0;

        if (sb.errors == 0 && sb.pending_xlats.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

>>> files.f
rtl/mtlb_pkg.sv
rtl/mtlb_div.sv
rtl/mmu_tlb_translate.sv
verif/tb.sv
